### rtl/core/piecewise_linear_distribution_query_assert.svh
// Assertion macros for the piecewise-linear distribution query block
`ifndef PIECEWISE_LINEAR_DISTRIBUTION_QUERY_ASSERT_SVH
`define PIECEWISE_LINEAR_DISTRIBUTION_QUERY_ASSERT_SVH

`ifndef SYNTHESIS
`define PLD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pld: same-cycle check failed");
`define PLD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pld: next-cycle check failed");
`else
`define PLD_ASSERT_NOW(label, ante, cons)
`define PLD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/core/pld_pkg.sv
// Types and constants of the piecewise-linear distribution query block
package pld_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   typedef logic [IDX_W-1:0] idx_type;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] MODE_DENS = 2'd0;
   localparam logic [1:0] MODE_CUM  = 2'd1;
   localparam logic [1:0] MODE_INV  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PROB  = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_TABLE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_POINT_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_QUERY_MODE  = 1'd1;

   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(2);
   localparam logic [CNT_W-1:0] MIN_USED    = CNT_W'(2);
   localparam logic [CNT_W-1:0] MAX_USED    = CNT_W'(MAX_POINTS);
   localparam logic [1:0]       MODE_RESET  = MODE_DENS;

   localparam logic [31:0] PROB_ONE = 32'h7FFF_FFFF;
   localparam logic [31:0] CUM_MAX  = 32'hFFFF_FFFF;

   localparam logic [6:0] DIV_STEPS  = 7'd64;
   localparam logic [5:0] SQRT_STEPS = 6'd32;

   typedef enum logic [17:0] {
      S_IDLE    = 18'h00001,
      S_LD_MUL  = 18'h00002,
      S_LD_WR   = 18'h00004,
      S_WALK    = 18'h00008,
      S_DRAIN   = 18'h00010,
      S_EVAL    = 18'h00020,
      S_IP_MUL  = 18'h00040,
      S_IP_DIV  = 18'h00080,
      S_CP_MUL  = 18'h00100,
      S_CP_ADD  = 18'h00200,
      S_IV_DIV1 = 18'h00400,
      S_IV_MUL  = 18'h00800,
      S_IV_DIV2 = 18'h01000,
      S_IV_SUM  = 18'h02000,
      S_SQRT    = 18'h04000,
      S_IV_DIV3 = 18'h08000,
      S_IV_FIN  = 18'h10000,
      S_DONE    = 18'h20000
   } state_type;

endpackage

### rtl/core/piecewise_linear_distribution_query.sv
// Piecewise-linear density table with density, cumulative and inverse cumulative queries
//
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  command, point index, position, density, query
// rsp      out        rsp_valid / rsp_ready  answer, status
// csr      in         csr_valid / csr_ready  register index, write data
//
// A load reads the previous entry, does the trapezoid multiply, then writes back.
// A query walks all n used points through the table memories, one entry a cycle.
// Then density and cumulative run the shared 64-step divider at most once, inverse up to
// three times, plus the 32-step square root.
// Reset is synchronous; the tables hold no reset state. A result waiting on rsp stalls
// only the next query at its last step.
`include "piecewise_linear_distribution_query_assert.svh"

module piecewise_linear_distribution_query (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_command,
   input  pld_pkg::idx_type                    req_point_index,
   input  logic signed [31:0]                  req_point_position,
   input  logic [30:0]                         req_point_density,
   input  logic signed [31:0]                  req_query_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [31:0]                  rsp_answer,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pld_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pld_pkg::CSR_DATA_W-1:0]      csr_data
);
   import pld_pkg::*;

   logic [31:0] pos_mem [MAX_POINTS];
   logic [30:0] den_mem [MAX_POINTS];
   logic [31:0] cum_mem [MAX_POINTS];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] point_count_ff;
   logic [1:0]       query_mode_ff;

   idx_type     ld_idx_ff, ld_idx_in;
   logic [31:0] ld_pos_ff, ld_pos_in;
   logic [30:0] ld_den_ff, ld_den_in;
   logic [31:0] q_val_ff, q_val_in;

   logic [CNT_W-1:0] rd_addr_ff, rd_addr_in;
   logic             rd_vld_ff, rd_vld_in;
   idx_type          rd_k_ff, rd_k_in;
   logic [31:0]      rd_pos_ff, rd_cum_ff;
   logic [30:0]      rd_den_ff;

   logic [31:0] first_pos_ff, first_pos_in;
   logic [31:0] cur_pos_ff, cur_pos_in, cur_cum_ff, cur_cum_in;
   logic [30:0] cur_den_ff, cur_den_in;
   logic        bad_ff, bad_in, found_ff, found_in;
   logic [31:0] s_p0_ff, s_p0_in, s_p1_ff, s_p1_in, s_c0_ff, s_c0_in;
   logic [30:0] s_d0_ff, s_d0_in, s_d1_ff, s_d1_in, f_ff, f_in;

   logic [63:0] prod_a_ff, prod_a_in, term_ff, term_in;
   logic [61:0] prod_b_ff, prod_b_in;
   logic [31:0] tc_ff, tc_in;

   logic [63:0] div_num_ff, div_num_in;
   logic [32:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [6:0]  div_cnt_ff, div_cnt_in;

   logic [63:0] sq_v_ff, sq_v_in, sq_r_ff, sq_r_in;
   logic [5:0]  sq_cnt_ff, sq_cnt_in;

   logic [31:0] res_ans_ff, res_ans_in;
   logic [1:0]  res_st_ff, res_st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_answer_ff, rsp_answer_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;

   logic             mem_we;
   idx_type          mem_ra;
   logic [31:0]      cum_wr;
   logic [CNT_W-1:0] n_used;

   logic [32:0] seg_w;
   logic [31:0] w32;
   logic        seg_up;
   logic [30:0] seg_mag;
   logic [32:0] x_off;
   logic [31:0] r_val;
   logic [32:0] four_r;
   logic        hit;

   logic [33:0] div_sh, div_sub;
   logic        div_ge;
   logic [63:0] sq_bit;
   logic [64:0] sq_try;

   logic [32:0] ld_dx;
   logic [31:0] ld_dsum;
   logic [63:0] ld_prod;
   logic [62:0] ld_sum;
   logic [62:0] ip_mt;
   logic [30:0] f_val;
   logic [63:0] cp_prod;
   logic [62:0] cp_sum;
   logic [64:0] iv_mq;
   logic [62:0] iv_mr;
   logic [63:0] sq_base, sq_s;
   logic [32:0] denom;
   logic [33:0] fin_sum;

   assign req_ready  = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

   always_comb begin
      if (point_count_ff < MIN_USED) begin
         n_used = MIN_USED;
      end else if (point_count_ff > MAX_USED) begin
         n_used = MAX_USED;
      end else begin
         n_used = point_count_ff;
      end
   end

   assign mem_we = (state_ff == S_LD_WR);
   assign mem_ra = (state_ff == S_IDLE) ? req_point_index - 1'b1 : rd_addr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pos_mem[ld_idx_ff] <= ld_pos_ff;
         den_mem[ld_idx_ff] <= ld_den_ff;
         cum_mem[ld_idx_ff] <= cum_wr;
      end
      rd_pos_ff <= pos_mem[mem_ra];
      rd_den_ff <= den_mem[mem_ra];
      rd_cum_ff <= cum_mem[mem_ra];
   end

   assign seg_w   = {s_p1_ff[31], s_p1_ff} - {s_p0_ff[31], s_p0_ff};
   assign w32     = seg_w[31:0];
   assign seg_up  = (s_d1_ff >= s_d0_ff);
   assign seg_mag = seg_up ? s_d1_ff - s_d0_ff : s_d0_ff - s_d1_ff;
   assign x_off   = {q_val_ff[31], q_val_ff} - {s_p0_ff[31], s_p0_ff};
   assign r_val   = ({1'b0, q_val_ff[30:0]} >= s_c0_ff) ?
                    {1'b0, q_val_ff[30:0]} - s_c0_ff : 32'd0;
   assign four_r  = {r_val[30:0], 2'b00};
   assign hit     = (query_mode_ff == MODE_INV) ? (rd_cum_ff > {1'b0, q_val_ff[30:0]})
                                                : ($signed(q_val_ff) <= $signed(rd_pos_ff));

   assign div_sh  = {div_rem_ff, div_num_ff[63]};
   assign div_ge  = (div_sh >= {1'b0, div_den_ff});
   assign div_sub = div_sh - {1'b0, div_den_ff};
   assign sq_bit  = 64'd1 << {sq_cnt_ff - 6'd1, 1'b0};
   assign sq_try  = {1'b0, sq_r_ff} + {1'b0, sq_bit};

   assign ld_dx   = {ld_pos_ff[31], ld_pos_ff} - {rd_pos_ff[31], rd_pos_ff};
   assign ld_dsum = {1'b0, ld_den_ff} + {1'b0, rd_den_ff};
   assign ld_prod = ld_dsum * ld_dx[31:0];
   assign ld_sum  = {31'd0, s_c0_ff} + {1'b0, prod_a_ff[63:2]};
   assign cum_wr  = (ld_sum > {31'd0, CUM_MAX}) ? CUM_MAX : ld_sum[31:0];
   assign ip_mt   = seg_mag * x_off[31:0];
   assign f_val   = seg_up ? s_d0_ff + div_num_ff[30:0] : s_d0_ff - div_num_ff[30:0];
   assign cp_prod = ({1'b0, f_ff} + {1'b0, s_d0_ff}) * x_off[31:0];
   assign cp_sum  = {31'd0, s_c0_ff} + {1'b0, prod_a_ff[63:2]};
   assign iv_mq   = seg_mag * div_num_ff[33:0];
   assign iv_mr   = seg_mag * div_rem_ff[31:0];
   assign sq_base = {2'b00, prod_b_ff};
   assign sq_s    = seg_up ? sq_base + term_ff :
                    ((sq_base > term_ff) ? sq_base - term_ff : 64'd0);
   assign denom   = {2'b00, s_d0_ff} + {1'b0, sq_r_ff[31:0]};
   assign fin_sum = {{2{s_p0_ff[31]}}, s_p0_ff} + {2'b00, tc_ff};

   always_comb begin
      state_in      = state_ff;
      ld_idx_in     = ld_idx_ff;
      ld_pos_in     = ld_pos_ff;
      ld_den_in     = ld_den_ff;
      q_val_in      = q_val_ff;
      rd_addr_in    = rd_addr_ff;
      rd_vld_in     = 1'b0;
      rd_k_in       = rd_k_ff;
      first_pos_in  = first_pos_ff;
      cur_pos_in    = cur_pos_ff;
      cur_den_in    = cur_den_ff;
      cur_cum_in    = cur_cum_ff;
      bad_in        = bad_ff;
      found_in      = found_ff;
      s_p0_in       = s_p0_ff;
      s_d0_in       = s_d0_ff;
      s_c0_in       = s_c0_ff;
      s_p1_in       = s_p1_ff;
      s_d1_in       = s_d1_ff;
      f_in          = f_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      term_in       = term_ff;
      tc_in         = tc_ff;
      res_ans_in    = res_ans_ff;
      res_st_in     = res_st_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_answer_in = rsp_answer_ff;
      rsp_status_in = rsp_status_ff;

      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      if (div_cnt_ff != 7'd0) begin
         div_cnt_in = div_cnt_ff - 7'd1;
         if (div_ge) begin
            div_rem_in = div_sub[32:0];
            div_num_in = {div_num_ff[62:0], 1'b1};
         end else begin
            div_rem_in = div_sh[32:0];
            div_num_in = {div_num_ff[62:0], 1'b0};
         end
      end

      sq_v_in   = sq_v_ff;
      sq_r_in   = sq_r_ff;
      sq_cnt_in = sq_cnt_ff;
      if (sq_cnt_ff != 6'd0) begin
         sq_cnt_in = sq_cnt_ff - 6'd1;
         if ({1'b0, sq_v_ff} >= sq_try) begin
            sq_v_in = sq_v_ff - sq_try[63:0];
            sq_r_in = (sq_r_ff >> 1) + sq_bit;
         end else begin
            sq_r_in = sq_r_ff >> 1;
         end
      end

      if (rd_vld_ff) begin
         cur_pos_in = rd_pos_ff;
         cur_den_in = rd_den_ff;
         cur_cum_in = rd_cum_ff;
         if (rd_k_ff == '0) begin
            first_pos_in = rd_pos_ff;
         end else begin
            if ($signed(rd_pos_ff) <= $signed(cur_pos_ff)) begin
               bad_in = 1'b1;
            end
            if (!found_ff && hit) begin
               found_in = 1'b1;
               s_p0_in  = cur_pos_ff;
               s_d0_in  = cur_den_ff;
               s_c0_in  = cur_cum_ff;
               s_p1_in  = rd_pos_ff;
               s_d1_in  = rd_den_ff;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ld_idx_in = req_point_index;
               ld_pos_in = req_point_position;
               ld_den_in = req_point_density;
               q_val_in  = req_query_value;
               if (req_command == CMD_LOAD) begin
                  state_in = S_LD_MUL;
               end else begin
                  rd_addr_in = '0;
                  bad_in     = 1'b0;
                  found_in   = 1'b0;
                  state_in   = S_WALK;
               end
            end
         end
         S_LD_MUL: begin
            if (ld_idx_ff != '0 && $signed(ld_dx) > 0) begin
               prod_a_in = ld_prod;
            end else begin
               prod_a_in = 64'd0;
            end
            s_c0_in  = (ld_idx_ff != '0) ? rd_cum_ff : 32'd0;
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            state_in = S_IDLE;
         end
         S_WALK: begin
            rd_vld_in  = 1'b1;
            rd_k_in    = rd_addr_ff[IDX_W-1:0];
            rd_addr_in = rd_addr_ff + 1'b1;
            if (rd_addr_ff == n_used - 1'b1) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            res_ans_in = 32'd0;
            res_st_in  = ST_OK;
            state_in   = S_DONE;
            priority case (query_mode_ff)
               MODE_DENS, MODE_CUM: begin
                  if (bad_ff) begin
                     res_st_in = ST_TABLE;
                  end else if ($signed(q_val_ff) < $signed(first_pos_ff)) begin
                     res_ans_in = 32'd0;
                  end else if ($signed(q_val_ff) > $signed(cur_pos_ff)) begin
                     res_ans_in = (query_mode_ff == MODE_CUM) ? PROB_ONE : 32'd0;
                  end else begin
                     state_in = S_IP_MUL;
                  end
               end
               MODE_INV: begin
                  if (q_val_ff[31]) begin
                     res_st_in = ST_PROB;
                  end else if (bad_ff) begin
                     res_st_in = ST_TABLE;
                  end else if (q_val_ff == 32'd0) begin
                     res_ans_in = first_pos_ff;
                  end else if (!found_ff) begin
                     res_ans_in = cur_pos_ff;
                  end else if (s_d0_ff == '0 && s_d1_ff == '0) begin
                     res_st_in = ST_ZERO;
                  end else begin
                     div_num_in = {31'd0, four_r};
                     div_den_in = {1'b0, w32};
                     div_rem_in = '0;
                     div_cnt_in = DIV_STEPS;
                     state_in   = S_IV_DIV1;
                  end
               end
               default: begin
                  res_ans_in = 32'd0;
               end
            endcase
         end
         S_IP_MUL: begin
            div_num_in = {1'b0, ip_mt};
            div_den_in = {1'b0, w32};
            div_rem_in = '0;
            div_cnt_in = DIV_STEPS;
            state_in   = S_IP_DIV;
         end
         S_IP_DIV: begin
            if (div_cnt_ff == 7'd0) begin
               if (query_mode_ff == MODE_DENS) begin
                  res_ans_in = {1'b0, f_val};
                  res_st_in  = ST_OK;
                  state_in   = S_DONE;
               end else begin
                  f_in     = f_val;
                  state_in = S_CP_MUL;
               end
            end
         end
         S_CP_MUL: begin
            prod_a_in = cp_prod;
            state_in  = S_CP_ADD;
         end
         S_CP_ADD: begin
            res_ans_in = (cp_sum > {31'd0, PROB_ONE}) ? PROB_ONE : cp_sum[31:0];
            res_st_in  = ST_OK;
            state_in   = S_DONE;
         end
         S_IV_DIV1: begin
            prod_b_in = s_d0_ff * s_d0_ff;
            if (div_cnt_ff == 7'd0) begin
               state_in = S_IV_MUL;
            end
         end
         S_IV_MUL: begin
            prod_a_in  = iv_mq[63:0];
            div_num_in = {1'b0, iv_mr};
            div_den_in = {1'b0, w32};
            div_rem_in = '0;
            div_cnt_in = DIV_STEPS;
            state_in   = S_IV_DIV2;
         end
         S_IV_DIV2: begin
            if (div_cnt_ff == 7'd0) begin
               term_in  = prod_a_ff + div_num_ff;
               state_in = S_IV_SUM;
            end
         end
         S_IV_SUM: begin
            sq_v_in   = sq_s;
            sq_r_in   = 64'd0;
            sq_cnt_in = SQRT_STEPS;
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            if (sq_cnt_ff == 6'd0) begin
               if (denom == 33'd0) begin
                  tc_in    = 32'd0;
                  state_in = S_IV_FIN;
               end else begin
                  div_num_in = {31'd0, four_r};
                  div_den_in = denom;
                  div_rem_in = '0;
                  div_cnt_in = DIV_STEPS;
                  state_in   = S_IV_DIV3;
               end
            end
         end
         S_IV_DIV3: begin
            if (div_cnt_ff == 7'd0) begin
               tc_in    = (div_num_ff > {32'd0, w32}) ? w32 : div_num_ff[31:0];
               state_in = S_IV_FIN;
            end
         end
         S_IV_FIN: begin
            res_ans_in = ($signed(fin_sum) > $signed({2'b00, PROB_ONE})) ?
                         PROB_ONE : fin_sum[31:0];
            res_st_in  = ST_OK;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_answer_in = res_ans_ff;
               rsp_status_in = res_st_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         point_count_ff <= COUNT_RESET;
         query_mode_ff  <= MODE_RESET;
         rd_vld_ff      <= 1'b0;
         div_cnt_ff     <= '0;
         sq_cnt_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         div_cnt_ff   <= div_cnt_in;
         sq_cnt_ff    <= sq_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index == REG_POINT_COUNT) begin
               point_count_ff <= csr_data[CNT_W-1:0];
            end
            if (csr_index == REG_QUERY_MODE) begin
               query_mode_ff <= csr_data[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      ld_idx_ff     <= ld_idx_in;
      ld_pos_ff     <= ld_pos_in;
      ld_den_ff     <= ld_den_in;
      q_val_ff      <= q_val_in;
      rd_addr_ff    <= rd_addr_in;
      rd_k_ff       <= rd_k_in;
      first_pos_ff  <= first_pos_in;
      cur_pos_ff    <= cur_pos_in;
      cur_den_ff    <= cur_den_in;
      cur_cum_ff    <= cur_cum_in;
      bad_ff        <= bad_in;
      found_ff      <= found_in;
      s_p0_ff       <= s_p0_in;
      s_d0_ff       <= s_d0_in;
      s_c0_ff       <= s_c0_in;
      s_p1_ff       <= s_p1_in;
      s_d1_ff       <= s_d1_in;
      f_ff          <= f_in;
      prod_a_ff     <= prod_a_in;
      prod_b_ff     <= prod_b_in;
      term_ff       <= term_in;
      tc_ff         <= tc_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_den_ff    <= div_den_in;
      sq_v_ff       <= sq_v_in;
      sq_r_ff       <= sq_r_in;
      res_ans_ff    <= res_ans_in;
      res_st_ff     <= res_st_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_status_ff <= rsp_status_in;
   end

   `PLD_ASSERT_NOW(a_idle_units, state_ff == S_IDLE, div_cnt_ff == '0 && sq_cnt_ff == '0)
   `PLD_ASSERT_NOW(a_walk_bound, state_ff == S_WALK, rd_addr_ff < n_used)
   `PLD_ASSERT_NOW(a_rsp_zero, rsp_valid_ff && rsp_status_ff != ST_OK, rsp_answer_ff == '0)
   `PLD_ASSERT_NOW(a_rsp_src, !rsp_valid_ff && rsp_valid_in, state_ff == S_DONE)
   `PLD_ASSERT_NEXT(a_load_seq, req_valid && req_ready && req_command == CMD_LOAD, state_ff == S_LD_MUL)

endmodule
